@@ hw/rtl/rtp_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, constants, angle table and cell tag types for the rect-to-polar converter.
// No dependencies; every module of the block imports this package.
package rtp_pkg;

    localparam int COORD_W     = 16;
    localparam int ITERATIONS  = 16;
    localparam int TABLE_LEN   = 32;
    localparam int ANG_FRAC    = 30;
    localparam int SCALE_SHIFT = 60 - COORD_W;

    localparam int CW   = SCALE_SHIFT + COORD_W + 3;
    localparam int ZW   = 35;
    localparam int DV_W = CW - 1 - ANG_FRAC;
    localparam int RW   = CW;
    localparam int NQ   = 20;

    localparam int SQ_W     = 2 * COORD_W + 1;
    localparam int SQ_STEPS = COORD_W;

    localparam int MAG_W = 16;
    localparam int ANG_W = 16;
    localparam int IN_W  = 2 * COORD_W;
    localparam int OUT_W = MAG_W + ANG_W;

    localparam int RAD_SH = ANG_FRAC - 13;
    localparam int DEG_SH = ANG_FRAC + 24 - 7;
    localparam int ZL_W   = 17;
    localparam int ZH_W   = ZW - ZL_W;
    localparam int DEG_K_W = 30;
    localparam int PH_W   = ZH_W + DEG_K_W + 1;
    localparam int PL_W   = ZL_W + DEG_K_W;
    localparam int PW     = PH_W + ZL_W;

    localparam int CSH_W = $clog2(ITERATIONS);
    localparam int DSH_W = $clog2(NQ);
    localparam int SSH_W = $clog2(2 * COORD_W);

    localparam int N_PIPE  = ITERATIONS + NQ + 5;
    localparam int MAG_DLY = N_PIPE - SQ_STEPS - 3;

    localparam int MAG_MAX = 46341;
    localparam int ANG_MAX = 25736;

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_ANGLE_UNIT = '0;

    localparam logic [DEG_K_W-1:0] DEG_PER_RAD_Q24 = 30'd961263669;
    localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

    localparam logic [29:0] ATAN_Q30 [TABLE_LEN] = '{
        30'd843314857, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd7,
        30'd3,         30'd1,         30'd0,         30'd0
    };

    typedef struct packed {
        logic origin;
    } t_cor_tag;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 neg;
        logic                 origin;
    } t_div_tag;

endpackage

@@ hw/rtl/rect_to_polar_converter.sv @@
`timescale 1ns / 1ps
// Top level of the rect-to-polar converter: stream ports, APB register, cell chains, skid.
// Depends on rtp_pkg, rtp_cordic_cell, rtp_div_cell and rtp_sqrt_cell.

// Converts one signed 16-bit point (x in tdata[15:0], y in tdata[31:16]) per clock, while
// the skid is empty, into its rounded distance from the origin (tdata[15:0]) and atan2(y, x)
// (tdata[31:16]), radians Q3.13 or, with angle_unit set, degrees Q9.7. A new point is taken
// every cycle while the skid is empty. Each result passes the fold stage, 16 CORDIC cells, one
// divider setup stage, 20 restoring-divider cells for the residual angle term, three stages
// of angle add, unit scaling and rounding, and the output register; the square root chain
// runs alongside. A skid stage behind the output register lets the block take input while a
// result waits; while the skid holds a result the whole chain holds. Write angle_unit only
// while the block is idle.
module rect_to_polar_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [rtp_pkg::IN_W-1:0]      i_s_tdata,   // x_coord, y_coord
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rtp_pkg::OUT_W-1:0]     o_m_tdata,   // magnitude, angle
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtp_pkg::APB_AW-1:0]    paddr,
    input  logic [rtp_pkg::APB_DW-1:0]    pwdata,
    output logic [rtp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import rtp_pkg::*;

    // control
    logic              w_en;
    logic              w_s_acc;
    logic              w_take;
    logic [N_PIPE-1:0] r_vld;
    logic              r_angle_unit;
    logic              w_reg_hit;

    // fold stage
    logic signed [COORD_W-1:0] w_in_x;
    logic signed [COORD_W-1:0] w_in_y;
    logic signed [CW-1:0]      w_x_sc;
    logic signed [CW-1:0]      w_y_sc;
    logic [COORD_W-1:0]        w_ax;
    logic [COORD_W-1:0]        w_ay;
    logic signed [CW-1:0]      r_p1_x;
    logic signed [CW-1:0]      r_p1_y;
    logic signed [ZW-1:0]      r_p1_z;
    t_cor_tag                  r_p1_tag;
    logic [2*COORD_W-1:0]      r_p1_sqx;
    logic [2*COORD_W-1:0]      r_p1_sqy;

    // CORDIC chain
    logic signed [CW-1:0] w_cx [ITERATIONS+1];
    logic signed [CW-1:0] w_cy [ITERATIONS+1];
    logic signed [ZW-1:0] w_cz [ITERATIONS+1];
    t_cor_tag             w_ctag [ITERATIONS+1];

    // divider chain
    logic [RW-1:0]   r_dp_rem;
    logic [DV_W-1:0] r_dp_dv;
    t_div_tag        r_dp_tag;
    logic [RW-1:0]   w_drem [NQ+1];
    logic [DV_W-1:0] w_ddv  [NQ+1];
    logic [NQ-1:0]   w_dq   [NQ+1];
    t_div_tag        w_dtag [NQ+1];

    // angle back end
    logic signed [ZW-1:0] w_qs;
    logic                 w_skip;
    logic signed [ZW-1:0] r_fz_z;
    logic                 r_fz_org;
    logic [ZW-1:0]        w_rad_sum;
    logic signed [PH_W-1:0] r_mul_ph;
    logic [PL_W-1:0]      r_mul_pl;
    logic [ANG_W-1:0]     r_mul_rad;
    logic                 r_mul_org;
    logic [PW-1:0]        w_deg_sum;
    logic [ANG_W-1:0]     r_fin_ang;

    // magnitude path
    logic [SQ_W-1:0]  r_sum;
    logic [SQ_W-1:0]  w_srem [SQ_STEPS+1];
    logic [SQ_W-1:0]  w_sres [SQ_STEPS+1];
    logic [SQ_W-1:0]  w_rnd;
    logic [MAG_W-1:0] r_rnd_mag;
    logic [MAG_W-1:0] r_mag_dly [MAG_DLY];

    // output register and skid
    logic [OUT_W-1:0] w_last_data;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_skid_valid;
    logic [OUT_W-1:0] r_skid_data;
    logic             n_out_valid;
    logic [OUT_W-1:0] n_out_data;
    logic             n_skid_valid;
    logic [OUT_W-1:0] n_skid_data;

    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;
    assign w_s_acc    = i_s_tvalid && w_en;
    assign w_take     = r_out_valid && i_m_tready;

    // configuration register
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[APB_AW-1:2] == REG_ANGLE_UNIT);
    assign prdata    = w_reg_hit ? {{(APB_DW-1){1'b0}}, r_angle_unit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_unit <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_reg_hit) begin
            r_angle_unit <= pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_PIPE-2:0], w_s_acc};
        end
    end

    // fold into the right half-plane
    assign w_in_x = $signed(i_s_tdata[COORD_W-1:0]);
    assign w_in_y = $signed(i_s_tdata[2*COORD_W-1:COORD_W]);
    assign w_x_sc = {{(CW-COORD_W-SCALE_SHIFT){w_in_x[COORD_W-1]}}, w_in_x,
                     {SCALE_SHIFT{1'b0}}};
    assign w_y_sc = {{(CW-COORD_W-SCALE_SHIFT){w_in_y[COORD_W-1]}}, w_in_y,
                     {SCALE_SHIFT{1'b0}}};
    assign w_ax   = w_in_x[COORD_W-1] ? $unsigned(-w_in_x) : $unsigned(w_in_x);
    assign w_ay   = w_in_y[COORD_W-1] ? $unsigned(-w_in_y) : $unsigned(w_in_y);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_in_x[COORD_W-1]) begin
                r_p1_x <= -w_x_sc;
                r_p1_y <= -w_y_sc;
                r_p1_z <= w_in_y[COORD_W-1] ? -PI_Q30 : PI_Q30;
            end else begin
                r_p1_x <= w_x_sc;
                r_p1_y <= w_y_sc;
                r_p1_z <= '0;
            end
            r_p1_tag.origin <= (w_in_x == '0) && (w_in_y == '0);
            r_p1_sqx        <= w_ax * w_ax;
            r_p1_sqy        <= w_ay * w_ay;
        end
    end

    assign w_cx[0]   = r_p1_x;
    assign w_cy[0]   = r_p1_y;
    assign w_cz[0]   = r_p1_z;
    assign w_ctag[0] = r_p1_tag;

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_cor
        rtp_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_sh   (CSH_W'(k)),
            .i_atan ($signed({{(ZW-30){1'b0}}, ATAN_Q30[k]})),
            .i_x    (w_cx[k]),
            .i_y    (w_cy[k]),
            .i_z    (w_cz[k]),
            .i_tag  (w_ctag[k]),
            .o_x    (w_cx[k+1]),
            .o_y    (w_cy[k+1]),
            .o_z    (w_cz[k+1]),
            .o_tag  (w_ctag[k+1])
        );
    end

    // set up residual division y / (x >> ANG_FRAC)
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dp_rem <= w_cy[ITERATIONS][CW-1] ? $unsigned(-w_cy[ITERATIONS])
                                                : $unsigned(w_cy[ITERATIONS]);
            r_dp_dv  <= w_cx[ITERATIONS][CW-1] ? '0 : w_cx[ITERATIONS][CW-2:ANG_FRAC];
            r_dp_tag <= '{z: w_cz[ITERATIONS], neg: w_cy[ITERATIONS][CW-1],
                          origin: w_ctag[ITERATIONS].origin};
        end
    end

    assign w_drem[0] = r_dp_rem;
    assign w_ddv[0]  = r_dp_dv;
    assign w_dq[0]   = '0;
    assign w_dtag[0] = r_dp_tag;

    for (genvar k = 0; k < NQ; k++) begin : g_div
        rtp_div_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_sh   (DSH_W'(NQ - 1 - k)),
            .i_rem  (w_drem[k]),
            .i_dv   (w_ddv[k]),
            .i_q    (w_dq[k]),
            .i_tag  (w_dtag[k]),
            .o_rem  (w_drem[k+1]),
            .o_dv   (w_ddv[k+1]),
            .o_q    (w_dq[k+1]),
            .o_tag  (w_dtag[k+1])
        );
    end

    // add the residual term, then scale and round
    assign w_qs   = $signed(ZW'(w_dq[NQ]));
    assign w_skip = (w_ddv[NQ] == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_skip) begin
                r_fz_z <= w_dtag[NQ].z;
            end else if (w_dtag[NQ].neg) begin
                r_fz_z <= w_dtag[NQ].z - w_qs;
            end else begin
                r_fz_z <= w_dtag[NQ].z + w_qs;
            end
            r_fz_org <= w_dtag[NQ].origin;
        end
    end

    assign w_rad_sum = $unsigned(r_fz_z) + (ZW'(1) << (RAD_SH - 1));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mul_ph  <= $signed(r_fz_z[ZW-1:ZL_W]) * $signed({1'b0, DEG_PER_RAD_Q24});
            r_mul_pl  <= r_fz_z[ZL_W-1:0] * DEG_PER_RAD_Q24;
            r_mul_rad <= w_rad_sum[RAD_SH+ANG_W-1:RAD_SH];
            r_mul_org <= r_fz_org;
        end
    end

    assign w_deg_sum = {r_mul_ph, {ZL_W{1'b0}}} + PW'(r_mul_pl) + (PW'(1) << (DEG_SH - 1));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_mul_org) begin
                r_fin_ang <= '0;
            end else if (r_angle_unit) begin
                r_fin_ang <= w_deg_sum[DEG_SH+ANG_W-1:DEG_SH];
            end else begin
                r_fin_ang <= r_mul_rad;
            end
        end
    end

    // magnitude: sum of squares, square root chain, round, align
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum <= SQ_W'(r_p1_sqx) + SQ_W'(r_p1_sqy);
        end
    end

    assign w_srem[0] = r_sum;
    assign w_sres[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        rtp_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_sh   (SSH_W'(2 * (SQ_STEPS - 1 - k))),
            .i_rem  (w_srem[k]),
            .i_res  (w_sres[k]),
            .o_rem  (w_srem[k+1]),
            .o_res  (w_sres[k+1])
        );
    end

    assign w_rnd = w_sres[SQ_STEPS] + SQ_W'(w_srem[SQ_STEPS] > w_sres[SQ_STEPS]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rnd_mag <= (w_rnd[SQ_W-1:MAG_W] != '0) ? '1 : w_rnd[MAG_W-1:0];
            r_mag_dly[0] <= r_rnd_mag;
            for (int i = 1; i < MAG_DLY; i++) begin
                r_mag_dly[i] <= r_mag_dly[i-1];
            end
        end
    end

    // output register with skid
    assign w_last_data = {r_fin_ang, r_mag_dly[MAG_DLY-1]};

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (r_vld[N_PIPE-1]) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out_data  = w_last_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = w_last_data;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ hw/rtl/rtp_cordic_cell.sv @@
`timescale 1ns / 1ps
// One vectoring CORDIC micro-rotation cell with its output register.
// Depends on rtp_pkg.
module rtp_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rtp_pkg::CSH_W-1:0]     i_sh,
    input  logic signed [rtp_pkg::ZW-1:0] i_atan,
    input  logic signed [rtp_pkg::CW-1:0] i_x,
    input  logic signed [rtp_pkg::CW-1:0] i_y,
    input  logic signed [rtp_pkg::ZW-1:0] i_z,
    input  rtp_pkg::t_cor_tag             i_tag,
    output logic signed [rtp_pkg::CW-1:0] o_x,
    output logic signed [rtp_pkg::CW-1:0] o_y,
    output logic signed [rtp_pkg::ZW-1:0] o_z,
    output rtp_pkg::t_cor_tag             o_tag
);
    import rtp_pkg::*;

    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    t_cor_tag             r_tag;

    assign w_xs = i_x >>> i_sh;
    assign w_ys = i_y >>> i_sh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[CW-1]) begin
                r_x <= i_x + w_ys;
                r_y <= i_y - w_xs;
                r_z <= i_z + i_atan;
            end else begin
                r_x <= i_x - w_ys;
                r_y <= i_y + w_xs;
                r_z <= i_z - i_atan;
            end
            r_tag <= i_tag;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_tag = r_tag;

endmodule

@@ hw/rtl/rtp_div_cell.sv @@
`timescale 1ns / 1ps
// One restoring-division cell: produces one quotient bit of the residual angle term.
// Depends on rtp_pkg.
module rtp_div_cell (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rtp_pkg::DSH_W-1:0] i_sh,
    input  logic [rtp_pkg::RW-1:0]    i_rem,
    input  logic [rtp_pkg::DV_W-1:0]  i_dv,
    input  logic [rtp_pkg::NQ-1:0]    i_q,
    input  rtp_pkg::t_div_tag         i_tag,
    output logic [rtp_pkg::RW-1:0]    o_rem,
    output logic [rtp_pkg::DV_W-1:0]  o_dv,
    output logic [rtp_pkg::NQ-1:0]    o_q,
    output rtp_pkg::t_div_tag         o_tag
);
    import rtp_pkg::*;

    logic [RW-1:0]   w_dsh;
    logic            w_ge;
    logic [RW-1:0]   r_rem;
    logic [DV_W-1:0] r_dv;
    logic [NQ-1:0]   r_q;
    t_div_tag        r_tag;

    assign w_dsh = RW'(i_dv) << i_sh;
    assign w_ge  = (i_rem >= w_dsh);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? (i_rem - w_dsh) : i_rem;
            r_q   <= {i_q[NQ-2:0], w_ge};
            r_dv  <= i_dv;
            r_tag <= i_tag;
        end
    end

    assign o_rem = r_rem;
    assign o_dv  = r_dv;
    assign o_q   = r_q;
    assign o_tag = r_tag;

endmodule

@@ hw/rtl/rtp_sqrt_cell.sv @@
`timescale 1ns / 1ps
// One digit-by-digit integer square root cell: settles one result bit per stage.
// Depends on rtp_pkg.
module rtp_sqrt_cell (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rtp_pkg::SSH_W-1:0] i_sh,
    input  logic [rtp_pkg::SQ_W-1:0]  i_rem,
    input  logic [rtp_pkg::SQ_W-1:0]  i_res,
    output logic [rtp_pkg::SQ_W-1:0]  o_rem,
    output logic [rtp_pkg::SQ_W-1:0]  o_res
);
    import rtp_pkg::*;

    logic [SQ_W-1:0] w_bit;
    logic [SQ_W-1:0] w_trial;
    logic            w_ge;
    logic [SQ_W-1:0] r_rem;
    logic [SQ_W-1:0] r_res;

    assign w_bit   = SQ_W'(1) << i_sh;
    assign w_trial = i_res + w_bit;
    assign w_ge    = (i_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_ge) begin
                r_rem <= i_rem - w_trial;
                r_res <= (i_res >> 1) + w_bit;
            end else begin
                r_rem <= i_rem;
                r_res <= i_res >> 1;
            end
        end
    end

    assign o_rem = r_rem;
    assign o_res = r_res;

endmodule

@@ hw/rtl/rtp_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the rect-to-polar converter, bound to the top level.
// Depends on rtp_pkg and rect_to_polar_converter.
module rtp_port_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_s_tready,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [rtp_pkg::OUT_W-1:0] o_m_tdata
);
    import rtp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output transaction changed while stalled");

    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_tready) |-> $past(o_m_tvalid && !i_m_tready))
        else $error("input ready dropped without an output stall");

    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready && i_m_tready |=> o_s_tready)
        else $error("input ready not restored after output drained");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[MAG_W-1:0] <= MAG_W'(MAG_MAX)))
        else $error("magnitude out of range");

    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[OUT_W-1:MAG_W]) <= ANG_MAX)
                    && ($signed(o_m_tdata[OUT_W-1:MAG_W]) >= -ANG_MAX))
        else $error("angle out of range");

endmodule

bind rect_to_polar_converter rtp_port_checker u_rtp_port_checker (.*);

@@ verif/rtp_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for rect_to_polar_converter: watches both stream channels and APB writes,
// predicts magnitude and atan2 angle per input transaction and compares each output.
// Depends on rtp_pkg for port widths and the register index.
module rtp_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [rtp_pkg::IN_W-1:0]      i_s_tdata,   // x_coord, y_coord
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [rtp_pkg::OUT_W-1:0]     i_m_tdata,   // magnitude, angle
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [rtp_pkg::APB_AW-1:0]    i_paddr,
    input  logic [rtp_pkg::APB_DW-1:0]    i_pwdata,
    input  logic                          i_pready,
    output int                            o_pending,
    output int                            o_fail_count
);

    typedef struct packed {
        logic signed [15:0] angle;
        logic        [15:0] magnitude;
    } t_polar;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint DEG_PER_RAD = 64'sd961263669;
    localparam int     PRE_SHIFT   = 44;

    longint atan_q30 [16] = '{
        843314857, 497837829, 263043836, 133525158,
        67021686,  33543515,  16775850,  8388437,
        4194282,   2097149,   1048575,   524287,
        262143,    131071,    65535,     32767
    };

    t_polar polar_q[$];
    logic   degrees_mode;
    int     fails;

    function automatic t_polar to_polar(input logic signed [15:0] xc,
                                        input logic signed [15:0] yc,
                                        input logic deg);
        longint          x0, y0, x, y, z, xs, ys, dv, ang;
        longint unsigned sum_sq, root, probe, rem;
        t_polar          r;
        x0 = xc;
        y0 = yc;
        sum_sq = x0 * x0 + y0 * y0;
        root = 0;
        probe = 64'd1 << 62;
        rem = sum_sq;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        if (rem > root)
            root++;
        if (root > 64'hFFFF)
            root = 64'hFFFF;
        r.magnitude = root[15:0];
        if (x0 == 0 && y0 == 0) begin
            r.angle = '0;
            return r;
        end
        x = x0 * (64'sd1 <<< PRE_SHIFT);
        y = y0 * (64'sd1 <<< PRE_SHIFT);
        z = 0;
        // fold into the right half-plane
        if (x0 < 0) begin
            x = -x;
            y = -y;
            z = (y0 >= 0) ? PI_Q30 : -PI_Q30;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q30[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q30[i];
            end
        end
        dv = x >>> 30;
        if (dv > 0)
            z = z + y / dv;
        if (deg)
            ang = (z * DEG_PER_RAD + (64'sd1 <<< 46)) >>> 47;
        else
            ang = (z + (64'sd1 <<< 16)) >>> 17;
        r.angle = ang[15:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_polar want, got;
        if (!i_rst_n) begin
            polar_q.delete();
            degrees_mode = 1'b0;
            fails = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[rtp_pkg::APB_AW-1:2] == rtp_pkg::REG_ANGLE_UNIT)
                degrees_mode = i_pwdata[0];
            if (i_s_tvalid && i_s_tready)
                polar_q.push_back(to_polar(i_s_tdata[15:0], i_s_tdata[31:16], degrees_mode));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (polar_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected transaction, actual mag %0d angle %0d",
                             $time, got.magnitude, got.angle);
                end else begin
                    want = polar_q.pop_front();
                    if (got.magnitude !== want.magnitude) begin
                        fails++;
                        $display("%0t: magnitude mismatch, expected %0d actual %0d",
                                 $time, want.magnitude, got.magnitude);
                    end
                    if (got.angle !== want.angle) begin
                        fails++;
                        $display("%0t: angle mismatch, expected %0d actual %0d",
                                 $time, want.angle, got.angle);
                    end
                end
            end
        end
        o_pending    <= polar_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for rect_to_polar_converter: clock, reset, point stimulus, APB writes,
// output backpressure and the verdict. Depends on rtp_pkg, the DUT and rtp_checker.
module tb;

    localparam int PHASE_ITEMS = 482;
    localparam logic [rtp_pkg::APB_AW-1:0] ADDR_ANGLE_UNIT = {rtp_pkg::REG_ANGLE_UNIT, 2'b00};
    localparam logic [rtp_pkg::APB_AW-1:0] ADDR_UNMAPPED   = 3'd4;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [rtp_pkg::IN_W-1:0]    s_tdata;    // x_coord, y_coord
    logic                        m_tvalid;
    logic                        m_tready;
    logic [rtp_pkg::OUT_W-1:0]   m_tdata;    // magnitude, angle
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rtp_pkg::APB_AW-1:0]  paddr;
    logic [rtp_pkg::APB_DW-1:0]  pwdata;
    logic [rtp_pkg::APB_DW-1:0]  prdata;
    logic                        pready;
    int                          pending;
    int                          fail_count;

    bit calm;
    bit long_hold;

    shortint corner_vals [5] = '{-32768, -1, 0, 1, 32767};
    shortint dir_x [20] = '{0, -32768, 32767, 0, 0, -32768, 32767, -32768, 32767, -1,
                            1, 0, 0, -1, -5, 3, -32768, -32768, 1, -1};
    shortint dir_y [20] = '{0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, 0,
                            0, 1, -1, -1, 0, 4, 1, -1, -32768, 32767};

    rect_to_polar_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    rtp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #800000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return corner_vals[$urandom_range(0, 4)];
            1, 2:    return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_point(input logic [15:0] xc, input logic [15:0] yc);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yc, xc};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [rtp_pkg::APB_AW-1:0] addr,
                             input logic [rtp_pkg::APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // output backpressure
    initial begin
        m_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 32)) @(posedge i_clk);
            end
        end
    end

    initial begin
        calm      = 1'b0;
        long_hold = 1'b0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 20; i++)
            send_point(dir_x[i], dir_y[i]);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: reg_write(ADDR_ANGLE_UNIT, 32'h0000_0001);
                1: reg_write(ADDR_ANGLE_UNIT, 32'hFFFF_FFFE);
                2: begin
                    reg_write(ADDR_ANGLE_UNIT, 32'h0000_0001);
                    reg_write(ADDR_UNMAPPED, 32'h0000_0000);
                end
                default: reg_write(ADDR_ANGLE_UNIT, 32'h0000_0000);
            endcase
            if (ph == 1)
                long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n >= PHASE_ITEMS / 2)
                    calm = 1'b1;
                send_point(pick_coord(), pick_coord());
            end
            drain();
        end

        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rtp_pkg.sv
hw/rtl/rtp_cordic_cell.sv
hw/rtl/rtp_div_cell.sv
hw/rtl/rtp_sqrt_cell.sv
hw/rtl/rect_to_polar_converter.sv
hw/rtl/rtp_checker.sv
verif/rtp_checker.sv
verif/tb.sv
